FILE: hdl/abft_pkg.sv
// Shared types and constants for the adaptive batch flush timer.
// No dependencies; imported by abft_div10, the top level and the checker.
`timescale 1ns / 1ps

package abft_pkg;

    // Field widths
    localparam int PERIOD_W   = 28;
    localparam int TIME_W     = 48;
    localparam int PEND_W     = 12;
    localparam int CNT_W      = 32;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_PAD_W   = OUT_TDATA_W - PERIOD_W - 2;

    // A flush with at least this many pending requests counts as full
    localparam int FULL_BATCH_DEPTH = 64;
    localparam int PEND_CMP_W       = PEND_W + 1;

    // Reset values of the period and its clamps (ns)
    localparam logic [PERIOD_W-1:0] PERIOD_RESET     = 28'd1000000;
    localparam logic [PERIOD_W-1:0] MIN_PERIOD_RESET = 28'd10000;
    localparam logic [PERIOD_W-1:0] MAX_PERIOD_RESET = 28'd250000000;

    // Divide by ten through a reciprocal: q = (x * 0xCCCCCCCD) >> 35, exact for 32-bit x
    localparam int          QUOT_W      = 25;
    localparam int          PROD_W      = PERIOD_W + 32;
    localparam int          RECIP_SHIFT = 35;
    localparam logic [31:0] RECIP_TEN   = 32'hCCCCCCCD;
    localparam logic [QUOT_W-1:0] QUOT_RESET = QUOT_W'(PERIOD_RESET / 10);

    // Rate test: request_count * 1e6 < period; only counts below 2^9 can pass
    localparam int          RATE_W      = 9;
    localparam int          RATE_PROD_W = PERIOD_W + 1;
    localparam logic [19:0] NS_PER_MS   = 20'd1000000;

    // Running ratio differences:
    //   hi = 9*full - 11*partial  (hi > 0 : full share above 0.55)
    //   lo = 11*full - 9*partial  (lo < 0 : full share below 0.45)
    localparam int RATIO_W = 38;
    localparam logic [RATIO_W-1:0] HI_FULL_STEP = 38'd9;
    localparam logic [RATIO_W-1:0] HI_PART_STEP = 38'd11;
    localparam logic [RATIO_W-1:0] LO_FULL_STEP = 38'd11;
    localparam logic [RATIO_W-1:0] LO_PART_STEP = 38'd9;

    // Request kinds carried on tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_REQUEST = 2'd0,
        KIND_FLUSH   = 2'd1,
        KIND_TUNE    = 2'd2
    } kind_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD = 2'd1;

    // Input request as held in the input register
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [PEND_W-1:0] pending;
        logic [TIME_W-1:0] now;
    } item_t;

    // Result word, laid out exactly as m_axis_tdata
    typedef struct packed {
        logic [OUT_PAD_W-1:0] pad;
        logic                 tuned;
        logic [PERIOD_W-1:0]  period;
        logic                 flush;
    } result_t;

endpackage

FILE: hdl/abft_div10.sv
// Registered divide-by-ten of the flush period, used for the grow and shrink steps.
// Depends on abft_pkg.
`timescale 1ns / 1ps

module abft_div10
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [abft_pkg::PERIOD_W-1:0] period,
    output logic [abft_pkg::QUOT_W-1:0]   quot
);
    import abft_pkg::*;

    logic [PROD_W-1:0] prod;
    logic [QUOT_W-1:0] quot_next;
    logic [QUOT_W-1:0] quot_reg;

    // Reciprocal multiply, quotient taken from the high bits
    assign prod      = PROD_W'(period) * PROD_W'(RECIP_TEN);
    assign quot_next = prod[RECIP_SHIFT +: QUOT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quot_reg <= QUOT_RESET;
        end
        else
        begin
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;

endmodule

FILE: hdl/adaptive_batch_flush_timer_top.sv
// Adaptive batch flush timer: handshake, configuration, counters and period tuning.
// Depends on abft_pkg and abft_div10.
`timescale 1ns / 1ps

// Usage
//   s_axis carries one request per transfer: tuser holds the kind (count an I/O
//   request, flush attempt, tuning pass), tdata holds now_ns and pending_count.
//   m_axis returns exactly one result per request: flush, period_ns, tuned.
//   cfg writes the period clamps (index 0 minimum, 1 maximum); it is always
//   ready and is meant to be used only while no request is in flight.
// Path: the input register holds a request, the result register its result.
// Throughput: one request per cycle unless m_axis stalls. Each request is
//   resolved combinationally between the input register and the result
//   register; the period/10 term comes from a registered reciprocal
//   multiplier that is refreshed every cycle, in time for the next tuning
//   pass able to act.
// Reset: period returns to 1 ms, clamps to 10 us and 250 ms, counters and the
//   flush time base to zero; both registers empty.
// Stall: while m_axis_tready is low the result holds; one more request can be
//   taken into the input register, after which s_axis_tready drops.

module adaptive_batch_flush_timer_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Requests
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [abft_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // now_ns[47:0], pending_count[59:48], zero pad
    input  logic [abft_pkg::KIND_W-1:0]          s_axis_tuser,   // req_type[1:0]
    // Results
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [abft_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // flush[0], period_ns[28:1], tuned[29], zero pad
    // Configuration
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [abft_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [abft_pkg::PERIOD_W-1:0]        cfg_data
);
    import abft_pkg::*;

    // Handshake registers
    logic    in_valid_reg,  in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg,   out_res_next;
    logic    fire;

    // Block state
    logic [PERIOD_W-1:0] min_reg,        min_next;
    logic [PERIOD_W-1:0] max_reg,        max_next;
    logic [PERIOD_W-1:0] period_reg,     period_next;
    logic [TIME_W-1:0]   last_flush_reg, last_flush_next;
    logic [CNT_W-1:0]    full_cnt_reg,   full_cnt_next;
    logic [CNT_W-1:0]    part_cnt_reg,   part_cnt_next;
    logic [CNT_W-1:0]    req_cnt_reg,    req_cnt_next;
    logic [RATIO_W-1:0]  ratio_hi_reg,   ratio_hi_next;
    logic [RATIO_W-1:0]  ratio_lo_reg,   ratio_lo_next;

    // Period divided by ten, trailing period_reg by one register
    logic [QUOT_W-1:0]   quot;

    // Decision terms
    logic [TIME_W-1:0]      elapsed;
    logic                   due;
    logic                   is_full;
    logic [RATE_PROD_W-1:0] rate_prod;
    logic                   rate_low;
    logic [PERIOD_W:0]      grow_sum;
    logic [PERIOD_W-1:0]    grow_period;
    logic                   rem_nz;
    logic [PERIOD_W-1:0]    shrink_diff;
    logic [PERIOD_W-1:0]    shrink_period;
    logic                   tune_en;
    logic                   flush_flag;
    logic                   tuned_flag;

    abft_div10 u_div10
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .period (period_reg),
        .quot   (quot)
    );

    // Pipeline handshake: one input register, one result register
    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_res_reg;
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (fire)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Flush timing and fill test
    assign elapsed = in_item_reg.now - last_flush_reg;
    assign due     = (elapsed >= TIME_W'(period_reg));
    assign is_full = (PEND_CMP_W'(in_item_reg.pending) >= PEND_CMP_W'(FULL_BATCH_DEPTH));

    // Request rate below one per millisecond
    assign rate_prod = RATE_PROD_W'(req_cnt_reg[RATE_W-1:0]) * RATE_PROD_W'(NS_PER_MS);
    assign rate_low  = (req_cnt_reg[CNT_W-1:RATE_W] == '0)
                       && (rate_prod < RATE_PROD_W'(period_reg));

    // Grow: period + floor(period/10), clamped to the maximum
    assign grow_sum    = (PERIOD_W+1)'(period_reg) + (PERIOD_W+1)'(quot);
    assign grow_period = (grow_sum > (PERIOD_W+1)'(max_reg)) ? max_reg
                                                             : grow_sum[PERIOD_W-1:0];

    // Shrink: period - ceil(period/10), clamped to the minimum
    assign rem_nz        = (PERIOD_W'({quot, 3'b000}) + PERIOD_W'({quot, 1'b0})) != period_reg;
    assign shrink_diff   = period_reg - PERIOD_W'(quot) - PERIOD_W'(rem_nz);
    assign shrink_period = (shrink_diff < min_reg) ? min_reg : shrink_diff;

    assign tune_en = (full_cnt_reg != '0) || (part_cnt_reg != '0);

    // Per-request state update
    always_comb
    begin
        period_next     = period_reg;
        last_flush_next = last_flush_reg;
        full_cnt_next   = full_cnt_reg;
        part_cnt_next   = part_cnt_reg;
        req_cnt_next    = req_cnt_reg;
        ratio_hi_next   = ratio_hi_reg;
        ratio_lo_next   = ratio_lo_reg;
        flush_flag      = 1'b0;
        tuned_flag      = 1'b0;

        if (fire)
        begin
            case (in_item_reg.kind)
                KIND_REQUEST:
                begin
                    if (req_cnt_reg != '1)
                        req_cnt_next = req_cnt_reg + 1'b1;
                end
                KIND_FLUSH:
                begin
                    if (due)
                    begin
                        flush_flag      = 1'b1;
                        last_flush_next = in_item_reg.now;
                        if (is_full)
                        begin
                            if (full_cnt_reg != '1)
                            begin
                                full_cnt_next = full_cnt_reg + 1'b1;
                                ratio_hi_next = ratio_hi_reg + HI_FULL_STEP;
                                ratio_lo_next = ratio_lo_reg + LO_FULL_STEP;
                            end
                        end
                        else
                        begin
                            if (part_cnt_reg != '1)
                            begin
                                part_cnt_next = part_cnt_reg + 1'b1;
                                ratio_hi_next = ratio_hi_reg - HI_PART_STEP;
                                ratio_lo_next = ratio_lo_reg - LO_PART_STEP;
                            end
                        end
                    end
                end
                KIND_TUNE:
                begin
                    if (tune_en)
                    begin
                        tuned_flag = 1'b1;
                        if (rate_low)
                            period_next = min_reg;
                        else if (!ratio_hi_reg[RATIO_W-1] && (ratio_hi_reg != '0))
                            period_next = grow_period;
                        else if (ratio_lo_reg[RATIO_W-1])
                            period_next = shrink_period;
                        full_cnt_next   = '0;
                        part_cnt_next   = '0;
                        req_cnt_next    = '0;
                        ratio_hi_next   = '0;
                        ratio_lo_next   = '0;
                        last_flush_next = in_item_reg.now;
                    end
                end
                default:
                begin
                end
            endcase
        end

        out_res_next        = out_res_reg;
        if (fire)
        begin
            out_res_next.pad    = '0;
            out_res_next.flush  = flush_flag;
            out_res_next.period = period_next;
            out_res_next.tuned  = tuned_flag;
        end
    end

    // Configuration writes
    always_comb
    begin
        min_next = min_reg;
        max_next = max_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MIN_PERIOD: min_next = cfg_data;
                CFG_MAX_PERIOD: max_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            min_reg        <= MIN_PERIOD_RESET;
            max_reg        <= MAX_PERIOD_RESET;
            period_reg     <= PERIOD_RESET;
            last_flush_reg <= '0;
            full_cnt_reg   <= '0;
            part_cnt_reg   <= '0;
            req_cnt_reg    <= '0;
            ratio_hi_reg   <= '0;
            ratio_lo_reg   <= '0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            min_reg        <= min_next;
            max_reg        <= max_next;
            period_reg     <= period_next;
            last_flush_reg <= last_flush_next;
            full_cnt_reg   <= full_cnt_next;
            part_cnt_reg   <= part_cnt_next;
            req_cnt_reg    <= req_cnt_next;
            ratio_hi_reg   <= ratio_hi_next;
            ratio_lo_reg   <= ratio_lo_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg.kind    <= s_axis_tuser;
            in_item_reg.pending <= s_axis_tdata[TIME_W +: PEND_W];
            in_item_reg.now     <= s_axis_tdata[TIME_W-1:0];
        end
        out_res_reg <= out_res_next;
    end

endmodule

FILE: hdl/abft_checker.sv
// Port-level checks for the adaptive batch flush timer, attached by bind.
// Depends on abft_pkg and adaptive_batch_flush_timer_top.
`timescale 1ns / 1ps

module abft_checker
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_axis_tready,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [abft_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import abft_pkg::*;

    result_t res;
    assign res = m_axis_tdata;

    // A result never shows both a fired flush and a tuning pass
    a_flush_tuned_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(res.flush && res.tuned))
        else $error("flush and tuned both set in one result");

    // Padding above the result fields stays zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (res.pad == '0))
        else $error("result padding not zero");

    // The input side only back-pressures when a result is stuck downstream
    a_ready_low_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("s_axis_tready low without a stalled result");

    // A stalled result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed or dropped");

endmodule

bind adaptive_batch_flush_timer_top abft_checker u_abft_checker (.*);

FILE: test/adaptive_batch_flush_timer_top_test.sv
// Self-checking testbench for adaptive_batch_flush_timer_top: directed and random requests.
// Depends on abft_pkg and the RTL only; predicts each result and checks it field by field.
`timescale 1ns / 1ps

module adaptive_batch_flush_timer_top_test;

    import abft_pkg::*;

    // Codes outside the package's named set
    localparam logic [KIND_W-1:0]    KIND_RESERVED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B   = 2'd3;
    localparam int ITEMS_PER_PHASE = 85;
    localparam int PHASES          = 6;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [KIND_W-1:0]      s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [PERIOD_W-1:0]    cfg_data      = '0;

    // Predicted block state
    logic [PERIOD_W-1:0] period_q   = PERIOD_RESET;
    logic [PERIOD_W-1:0] min_clamp  = MIN_PERIOD_RESET;
    logic [PERIOD_W-1:0] max_clamp  = MAX_PERIOD_RESET;
    logic [TIME_W-1:0]   flushed_at = '0;
    logic [CNT_W-1:0]    full_cnt   = '0;
    logic [CNT_W-1:0]    part_cnt   = '0;
    logic [CNT_W-1:0]    req_cnt    = '0;

    result_t expected_results[$];

    // Stimulus bookkeeping
    logic [TIME_W-1:0] clock_ns = '0;
    bit steady = 1'b0;
    int mismatches      = 0;
    int requests_sent   = 0;
    int results_checked = 0;
    int flushes_fired   = 0;
    int tunes_applied   = 0;
    int clamp_writes    = 0;

    adaptive_batch_flush_timer_top u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    // Result side back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= steady || ($urandom_range(0, 99) >= 25);
    end

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // Flush period after a tuning pass with at least one flush counted
    function automatic logic [PERIOD_W-1:0] tuned_period();
        logic [63:0] total;
        logic [63:0] scaled;
        total = 64'(full_cnt) + 64'(part_cnt);
        if (64'(req_cnt) * 64'd1000000 < 64'(period_q))
            return min_clamp;
        if (64'(full_cnt) * 64'd20 > total * 64'd11)
        begin
            scaled = 64'(period_q) * 64'd11 / 64'd10;
            return (scaled > 64'(max_clamp)) ? max_clamp : scaled[PERIOD_W-1:0];
        end
        if (64'(full_cnt) * 64'd20 < total * 64'd9)
        begin
            scaled = 64'(period_q) * 64'd9 / 64'd10;
            return (scaled < 64'(min_clamp)) ? min_clamp : scaled[PERIOD_W-1:0];
        end
        return period_q;
    endfunction

    // Advance the predicted state by one request and queue its result
    function automatic void predict_result(input logic [KIND_W-1:0] kind,
                                           input logic [TIME_W-1:0] now,
                                           input logic [PEND_W-1:0] pend);
        result_t r;
        logic [TIME_W-1:0] elapsed;
        r = '0;
        case (kind)
            KIND_REQUEST:
                req_cnt = bump(req_cnt);
            KIND_FLUSH:
            begin
                elapsed = now - flushed_at;
                if (elapsed >= TIME_W'(period_q))
                begin
                    if (32'(pend) < FULL_BATCH_DEPTH)
                        part_cnt = bump(part_cnt);
                    else
                        full_cnt = bump(full_cnt);
                    flushed_at = now;
                    r.flush = 1'b1;
                    flushes_fired++;
                end
            end
            KIND_TUNE:
            begin
                if ((64'(full_cnt) + 64'(part_cnt)) != 0)
                begin
                    period_q   = tuned_period();
                    full_cnt   = '0;
                    part_cnt   = '0;
                    req_cnt    = '0;
                    flushed_at = now;
                    r.tuned = 1'b1;
                    tunes_applied++;
                end
            end
            default: ;
        endcase
        r.period = period_q;
        expected_results.push_back(r);
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH at %0t ns: %s got 0x%0h, expected 0x%0h", $time, field, got, want);
        mismatches++;
    endtask

    // Compare each accepted result with the oldest prediction
    always @(negedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = result_t'(m_axis_tdata);
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", 64'(got), 64'd0);
            else
            begin
                want = expected_results.pop_front();
                if (got.flush !== want.flush)
                    report_mismatch("flush", 64'(got.flush), 64'(want.flush));
                if (got.period !== want.period)
                    report_mismatch("period_ns", 64'(got.period), 64'(want.period));
                if (got.tuned !== want.tuned)
                    report_mismatch("tuned", 64'(got.tuned), 64'(want.tuned));
                if (got.pad !== want.pad)
                    report_mismatch("pad", 64'(got.pad), 64'(want.pad));
            end
            results_checked++;
        end
    end

    // One request; tvalid stays high unless a gap follows
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] now,
                                input logic [PEND_W-1:0] pend);
        while (!steady && $urandom_range(0, 99) < 25)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {4'b0, pend, now};
        do
            @(negedge clk);
        while (!s_axis_tready);
        @(posedge clk);
        predict_result(kind, now, pend);
        requests_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_clamp(input logic [CFG_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        if (idx == CFG_MIN_PERIOD)
            min_clamp = value;
        else if (idx == CFG_MAX_PERIOD)
            max_clamp = value;
        clamp_writes++;
    endtask

    task automatic load_clamps(input logic [PERIOD_W-1:0] lo, input logic [PERIOD_W-1:0] hi);
        drain_results();
        write_clamp(CFG_MIN_PERIOD, lo);
        write_clamp(CFG_MAX_PERIOD, hi);
        cfg_valid <= 1'b0;
    endtask

    // Flush at exactly one period, some I/O requests, then a tuning pass
    task automatic tuning_round(input bit full_batch, input int unsigned n_req);
        send_request(KIND_FLUSH, flushed_at + TIME_W'(period_q), full_batch ? 12'd100 : 12'd5);
        repeat (n_req)
            send_request(KIND_REQUEST, 48'd0, 12'd0);
        send_request(KIND_TUNE, flushed_at, 12'd0);
    endtask

    // Every kind at the reset clamps, depth boundary, dead-band tuning
    task automatic test_request_kinds();
        send_request(KIND_TUNE, 48'd0, 12'd0);             // nothing flushed yet: no tune
        send_request(KIND_RESERVED, '1, '1);               // ignored
        send_request(KIND_FLUSH, 48'd999999, 12'hFFF);     // one short of the period
        send_request(KIND_FLUSH, 48'd1000000, 12'd64);     // fires, full at the depth
        send_request(KIND_FLUSH, 48'd2000000, 12'd63);     // fires, just partial
        send_request(KIND_REQUEST, 48'd0, 12'd0);
        send_request(KIND_TUNE, 48'd2000000, 12'd0);       // ratio 0.5: period kept
    endtask

    // Elapsed time across the 48-bit wrap
    task automatic test_clock_wrap();
        send_request(KIND_FLUSH, 48'hFFFF_FFFF_FFFF, 12'd0);
        send_request(KIND_FLUSH, TIME_W'(period_q) - 48'd2, 12'hFFF);
        send_request(KIND_FLUSH, TIME_W'(period_q) - 48'd1, 12'hFFF);
    endtask

    // Grow, shrink, snap, both clamps, crossed clamps, zero period, spare indexes
    task automatic test_period_tuning();
        drain_results();
        write_clamp(CFG_SPARE_A, 28'hFFF_FFFF);
        write_clamp(CFG_SPARE_B, 28'd0);
        load_clamps(28'd1000, 28'd1200000);
        tuning_round(1'b1, 1);      // grow
        tuning_round(1'b1, 2);      // grow, held at the maximum
        tuning_round(1'b0, 2);      // shrink
        tuning_round(1'b0, 0);      // slow rate: snap to the minimum
        load_clamps(28'd5000, 28'd100);
        tuning_round(1'b1, 1);      // grow clamped to a maximum below the minimum
        tuning_round(1'b0, 1);      // shrink clamped up to the minimum
        load_clamps(28'd0, 28'd100);
        tuning_round(1'b0, 0);      // snap to a zero period
        tuning_round(1'b1, 0);      // zero period: rate test false, ratio decides
    endtask

    // One random request; returns 0 for an ignored kind
    task automatic random_request(output bit counted);
        logic [TIME_W-1:0] now;
        logic [PEND_W-1:0] pend;
        logic [KIND_W-1:0] kind;
        logic [63:0]       step;
        int unsigned       pick;
        pick    = $urandom_range(0, 99);
        now     = {16'($urandom), 32'($urandom)};
        counted = 1'b1;
        case ($urandom_range(0, 3))
            0:       pend = 12'($urandom_range(0, FULL_BATCH_DEPTH - 1));
            1:       pend = 12'($urandom_range(FULL_BATCH_DEPTH, 2 * FULL_BATCH_DEPTH));
            default: pend = 12'($urandom);
        endcase
        if ($urandom_range(0, 9) < 6)
            step = 64'(period_q) + 64'($urandom_range(0, 32'(period_q) / 4));
        else
            step = 64'($urandom_range(0, 32'(period_q)));
        if (pick < 40)
            kind = KIND_REQUEST;
        else if (pick < 80)
        begin
            kind = KIND_FLUSH;
            clock_ns = clock_ns + step[TIME_W-1:0];
            now = clock_ns;
        end
        else if (pick < 92)
        begin
            kind = KIND_TUNE;
            now = clock_ns;
        end
        else if (pick < 96)
        begin
            kind = KIND_RESERVED;
            counted = 1'b0;
        end
        else
        begin
            // flush at an arbitrary time
            kind = KIND_FLUSH;
            clock_ns = now;
        end
        send_request(kind, now, pend);
    endtask

    // Random traffic over several clamp settings, extremes included
    task automatic test_random_traffic();
        logic [PERIOD_W-1:0] lo;
        logic [PERIOD_W-1:0] hi;
        int  ph;
        int  n;
        bit  counted;
        clock_ns = flushed_at;
        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: begin lo = 28'd500;       hi = 28'd3000000;   end
                1: begin lo = 28'd1;         hi = 28'hFFF_FFFF;  end
                2: begin lo = 28'hFFF_FFFF;  hi = 28'hFFF_FFFF;  end
                3: begin lo = 28'd1;         hi = 28'd1;         end
                4:
                begin
                    lo = 28'($urandom_range(1, 2000000));
                    hi = lo + 28'($urandom_range(0, 5000000));
                end
                default:
                begin
                    lo = 28'($urandom_range(2000000, 4000000));
                    hi = 28'($urandom_range(1, 1999999));
                end
            endcase
            load_clamps(lo, hi);
            steady = (ph == 0);
            n = 0;
            while (n < ITEMS_PER_PHASE)
            begin
                random_request(counted);
                if (counted)
                    n++;
            end
            steady = 1'b0;
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_request_kinds();
        test_clock_wrap();
        test_period_tuning();
        test_random_traffic();
        drain_results();
        repeat (8) @(posedge clk);
        $display("Sent %0d requests (%0d flushes fired, %0d tuning passes applied), %0d clamp writes",
                 requests_sent, flushes_fired, tunes_applied, clamp_writes);
        $display("Compared %0d results, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("adaptive_batch_flush_timer_top verification clean");
        else
            $display("adaptive_batch_flush_timer_top verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4_000_000;
        $display("Timeout with %0d results outstanding", expected_results.size());
        $display("adaptive_batch_flush_timer_top verification failed");
        $finish;
    end

endmodule
